// ----- src/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define MDU_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked on every edge, reset included
`define MDU_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/mdu_pkg.sv -----
package mdu_pkg;

    localparam int FUNC_W  = 4;
    localparam int WORD_W  = 64;
    localparam int HALF_W  = WORD_W / 2;
    localparam int CNT_W   = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam logic [WORD_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [FUNC_W-1:0] {
        F_MULT   = 4'd0,
        F_MULTU  = 4'd1,
        F_DMULT  = 4'd2,
        F_DMULTU = 4'd3,
        F_DIV    = 4'd4,
        F_DIVU   = 4'd5,
        F_DDIV   = 4'd6,
        F_DDIVU  = 4'd7,
        F_MFHI   = 4'd8,
        F_MFLO   = 4'd9,
        F_MTHI   = 4'd10,
        F_MTLO   = 4'd11
    } t_func;

    function automatic t_word sext32(input logic [HALF_W-1:0] x);
        return {{HALF_W{x[HALF_W-1]}}, x};
    endfunction

    function automatic t_word zext32(input logic [HALF_W-1:0] x);
        return {{HALF_W{1'b0}}, x};
    endfunction

endpackage

// ----- src/mdu_if.sv -----
// request channel: operation and two source values
interface mdu_req_if;
    logic                                valid;
    logic                                ready;
    logic [mdu_pkg::FUNC_W-1:0]          func;
    logic signed [mdu_pkg::WORD_W-1:0]   rs_value;
    logic signed [mdu_pkg::WORD_W-1:0]   rt_value;

    modport source (output valid, func, rs_value, rt_value, input ready);
    modport sink   (input valid, func, rs_value, rt_value, output ready);
endinterface

// response channel: move-from data and write-back flag
interface mdu_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [mdu_pkg::WORD_W-1:0]   read_data;
    logic                                writes_back;

    modport source (output valid, read_data, writes_back, input ready);
    modport sink   (input valid, read_data, writes_back, output ready);
endinterface

// ----- src/mips64_mul_div_hilo_unit.sv -----
// channel  | dir | payload                        | handshake
// i_req    | in  | func, rs_value, rt_value       | valid/ready
// o_rsp    | out | read_data, writes_back         | valid/ready
//
// moves and unused codes: result word registered, valid in the cycle after accept
// multiply and divide: S_ABS_A, S_ABS_B, then the 64-step shift-add / restoring-divide
//   loop on the single 66-bit adder, then S_FIX_Q, S_FIX_R and S_FIN
// no new word is taken while a multiply or divide is in flight
// sync active-low reset clears hi, lo, the sequencer and the result slot
// a stalled result holds in its register; a new word is taken once it leaves
`include "assert_macros.svh"

module mips64_mul_div_hilo_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mdu_req_if.sink       i_req,
    mdu_rsp_if.source     o_rsp
);
    import mdu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABS_A,
        S_ABS_B,
        S_ITER,
        S_FIX_Q,
        S_FIX_R,
        S_FIN
    } t_state;

    t_state             r_state,   n_state;
    t_func              r_func,    n_func;
    logic [CNT_W-1:0]   r_count,   n_count;
    t_word              r_hi,      n_hi;
    t_word              r_lo,      n_lo;
    t_word              r_hi_acc,  n_hi_acc;
    t_word              r_lo_acc,  n_lo_acc;
    t_word              r_opd,     n_opd;
    t_word              r_rt,      n_rt;
    logic               r_is_div,  n_is_div;
    logic               r_neg_a,   n_neg_a;
    logic               r_neg_b,   n_neg_b;
    logic               r_out_valid, n_out_valid;
    t_word              r_rd,      n_rd;
    logic               r_wb,      n_wb;

    logic [WORD_W:0]    add_x;
    logic [WORD_W:0]    add_y;
    logic               add_cin;
    logic [WORD_W+1:0]  add_sum;
    logic               req_ok;
    logic               slot_free;
    logic               div_carry;

    assign slot_free     = !r_out_valid || o_rsp.ready;
    assign i_req.ready   = (r_state == S_IDLE) && slot_free;
    assign req_ok        = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.read_data   = r_rd;
    assign o_rsp.writes_back = r_wb;

    // the one shared adder; default is a two's complement negate of lo_acc
    always_comb begin
        add_x   = {1'b0, ~r_lo_acc};
        add_y   = '0;
        add_cin = 1'b1;
        unique case (r_state)
            S_ABS_B: add_x = {1'b0, ~r_opd};
            S_ITER: begin
                if (r_is_div) begin
                    add_x = {r_hi_acc, r_lo_acc[WORD_W-1]};
                    add_y = ~{1'b0, r_opd};
                end else begin
                    add_x   = {1'b0, r_hi_acc};
                    add_y   = r_lo_acc[0] ? {1'b0, r_opd} : '0;
                    add_cin = 1'b0;
                end
            end
            S_FIX_Q: begin
                if (!r_is_div) begin
                    // signed product correction: hi minus rt
                    add_x = {1'b0, r_hi_acc};
                    add_y = {1'b0, ~r_rt};
                end
            end
            S_FIX_R: begin
                if (r_is_div) begin
                    add_x = {1'b0, ~r_hi_acc};
                end else begin
                    add_x = {1'b0, r_hi_acc};
                    add_y = {1'b0, ~r_opd};
                end
            end
            default: ;
        endcase
        add_sum = {1'b0, add_x} + {1'b0, add_y} + {{(WORD_W+1){1'b0}}, add_cin};
    end

    assign div_carry = add_sum[WORD_W+1];

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_count     = r_count;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_hi_acc    = r_hi_acc;
        n_lo_acc    = r_lo_acc;
        n_opd       = r_opd;
        n_rt        = r_rt;
        n_is_div    = r_is_div;
        n_neg_a     = r_neg_a;
        n_neg_b     = r_neg_b;
        n_out_valid = r_out_valid;
        n_rd        = r_rd;
        n_wb        = r_wb;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (req_ok) begin
                    n_func   = t_func'(i_req.func);
                    n_hi_acc = '0;
                    n_count  = '0;
                    n_rt     = i_req.rt_value;
                    n_is_div = 1'b0;
                    n_neg_a  = 1'b0;
                    n_neg_b  = 1'b0;
                    n_rd     = '0;
                    n_wb     = 1'b0;
                    n_state  = S_ABS_A;
                    unique case (t_func'(i_req.func)) inside
                        F_MULT: begin
                            n_opd    = sext32(i_req.rs_value[HALF_W-1:0]);
                            n_lo_acc = sext32(i_req.rt_value[HALF_W-1:0]);
                        end
                        F_MULTU: begin
                            n_opd    = zext32(i_req.rs_value[HALF_W-1:0]);
                            n_lo_acc = zext32(i_req.rt_value[HALF_W-1:0]);
                        end
                        F_DMULT: begin
                            n_opd    = i_req.rs_value;
                            n_lo_acc = i_req.rt_value;
                            n_neg_a  = i_req.rs_value[WORD_W-1];
                            n_neg_b  = i_req.rt_value[WORD_W-1];
                        end
                        F_DMULTU: begin
                            n_opd    = i_req.rs_value;
                            n_lo_acc = i_req.rt_value;
                        end
                        F_DIV: begin
                            n_lo_acc = sext32(i_req.rs_value[HALF_W-1:0]);
                            n_opd    = sext32(i_req.rt_value[HALF_W-1:0]);
                            n_is_div = 1'b1;
                            n_neg_a  = i_req.rs_value[HALF_W-1];
                            n_neg_b  = i_req.rt_value[HALF_W-1];
                        end
                        F_DIVU: begin
                            n_lo_acc = zext32(i_req.rs_value[HALF_W-1:0]);
                            n_opd    = zext32(i_req.rt_value[HALF_W-1:0]);
                            n_is_div = 1'b1;
                        end
                        F_DDIV: begin
                            n_lo_acc = i_req.rs_value;
                            n_opd    = i_req.rt_value;
                            n_is_div = 1'b1;
                            n_neg_a  = i_req.rs_value[WORD_W-1];
                            n_neg_b  = i_req.rt_value[WORD_W-1];
                        end
                        F_DDIVU: begin
                            n_lo_acc = i_req.rs_value;
                            n_opd    = i_req.rt_value;
                            n_is_div = 1'b1;
                        end
                        F_MFHI, F_MFLO: begin
                            n_rd        = (t_func'(i_req.func) == F_MFHI) ? r_hi : r_lo;
                            n_wb        = 1'b1;
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                        F_MTHI: begin
                            n_hi        = i_req.rs_value;
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                        F_MTLO: begin
                            n_lo        = i_req.rs_value;
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    endcase
                end
            end
            S_ABS_A: begin
                if (r_is_div && r_neg_a) begin
                    n_lo_acc = add_sum[WORD_W-1:0];
                end
                n_state = S_ABS_B;
            end
            S_ABS_B: begin
                if (r_is_div && r_neg_b) begin
                    n_opd = add_sum[WORD_W-1:0];
                end
                n_state = S_ITER;
            end
            S_ITER: begin
                if (r_is_div) begin
                    // restoring step: keep the trial remainder when no borrow
                    n_hi_acc = div_carry ? add_sum[WORD_W-1:0]
                                         : {r_hi_acc[WORD_W-2:0], r_lo_acc[WORD_W-1]};
                    n_lo_acc = {r_lo_acc[WORD_W-2:0], div_carry};
                end else begin
                    n_hi_acc = add_sum[WORD_W:1];
                    n_lo_acc = {add_sum[0], r_lo_acc[WORD_W-1:1]};
                end
                n_count = r_count + CNT_W'(1);
                if (r_count == CNT_W'(WORD_W - 1)) begin
                    n_state = S_FIX_Q;
                end
            end
            S_FIX_Q: begin
                if (r_is_div) begin
                    if (r_neg_a ^ r_neg_b) begin
                        n_lo_acc = add_sum[WORD_W-1:0];
                    end
                end else if (r_neg_a) begin
                    n_hi_acc = add_sum[WORD_W-1:0];
                end
                n_state = S_FIX_R;
            end
            S_FIX_R: begin
                // remainder takes the dividend sign; product loses rs when rt is negative
                if ((r_is_div && r_neg_a) || (!r_is_div && r_neg_b)) begin
                    n_hi_acc = add_sum[WORD_W-1:0];
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (slot_free) begin
                    unique case (r_func) inside
                        F_MULT, F_MULTU: begin
                            n_hi = sext32(r_lo_acc[WORD_W-1:HALF_W]);
                            n_lo = sext32(r_lo_acc[HALF_W-1:0]);
                        end
                        F_DIVU: begin
                            n_hi = sext32(r_hi_acc[HALF_W-1:0]);
                            n_lo = sext32(r_lo_acc[HALF_W-1:0]);
                        end
                        default: begin
                            n_hi = r_hi_acc;
                            n_lo = r_lo_acc;
                        end
                    endcase
                    n_rd        = '0;
                    n_wb        = 1'b0;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_hi        <= '0;
            r_lo        <= '0;
            r_count     <= '0;
            r_is_div    <= 1'b0;
            r_neg_a     <= 1'b0;
            r_neg_b     <= 1'b0;
            r_func      <= F_MULT;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_hi        <= n_hi;
            r_lo        <= n_lo;
            r_count     <= n_count;
            r_is_div    <= n_is_div;
            r_neg_a     <= n_neg_a;
            r_neg_b     <= n_neg_b;
            r_func      <= n_func;
        end
        r_hi_acc <= n_hi_acc;
        r_lo_acc <= n_lo_acc;
        r_opd    <= n_opd;
        r_rt     <= n_rt;
        r_rd     <= n_rd;
        r_wb     <= n_wb;
    end

    `MDU_ASSERT(a_busy_not_ready, i_clk, i_rst_n, (r_state != S_IDLE) |-> !i_req.ready, "request taken while busy")
    `MDU_ASSERT(a_iter_count, i_clk, i_rst_n, (r_state == S_ITER && r_count != CNT_W'(WORD_W - 1)) |=> (r_state == S_ITER && r_count == $past(r_count) + CNT_W'(1)), "iteration count broke")
    `MDU_ASSERT(a_hilo_stable, i_clk, i_rst_n, (r_state != S_FIN && !req_ok) |=> ($stable(r_hi) && $stable(r_lo)), "hi or lo changed outside a write")
    `MDU_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE && !r_out_valid), "not idle after reset")

endmodule
